[sv/cbd_pkg.sv]
// shared types and constants for the center-crop bilinear downscaler
// no dependencies; used by cbd_blend and the top level
package cbd_pkg;

  localparam int PIX_W     = 8;
  localparam int FRAC_W    = 8;
  localparam int FIX_SHIFT = 16;
  localparam int COORD_W   = 6;
  localparam int CFG_W     = 11;
  localparam int WIDTH_RST  = 320;
  localparam int HEIGHT_RST = 240;
  localparam logic [PIX_W-1:0] PIX_OFFSET = 8'h80;

  // configuration register indexes
  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  // operands of one blend step: base + asr8(frac * (other - base))
  typedef struct packed {
    logic [FRAC_W-1:0] frac;
    logic [PIX_W-1:0]  base;
    logic [PIX_W-1:0]  other;
  } blend_req_t;

endpackage

[sv/cbd_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module cbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/cbd_div.sv]
// step-size unit: (dividend << Shift) / Divisor by reciprocal multiplication
// no dependencies; one registered multiply, quotient valid in the cycle after start
module cbd_div #(
  parameter int DimW    = 11,
  parameter int Shift   = 16,
  parameter int Divisor = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DimW-1:0]       dividend_i,
  output logic                  done_o,
  output logic [DimW+Shift-1:0] quot_o
);

  localparam int NumW  = DimW + Shift;
  localparam int LogD  = $clog2(Divisor);
  localparam int RecS  = NumW + LogD;
  localparam int RecW  = NumW + 1;
  localparam int ProdW = DimW + LogD + NumW;
  // ceil(2^RecS / Divisor) is exact for every dividend below 2^NumW
  localparam logic [63:0] RecipL = ((64'd1 << RecS) + 64'(Divisor) - 64'd1) / 64'(Divisor);
  localparam logic [RecW-1:0] Recip = RecipL[RecW-1:0];

  logic [ProdW-1:0] prod;

  // the shifted-in zeros fold into the final shift
  always_comb begin
    prod = ProdW'(dividend_i) * ProdW'(Recip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_o <= prod[DimW+LogD +: NumW];
    end
  end

endmodule

[sv/cbd_blend.sv]
// shared blend unit: one signed multiply, arithmetic shift and add, registered
// depends on cbd_pkg for the request struct
module cbd_blend (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  cbd_pkg::blend_req_t      req_i,
  output logic [cbd_pkg::PIX_W-1:0] res_o
);

  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic signed [17:0] shifted;
  logic signed [9:0]  sum;

  // floor shift keeps the result between base and other
  always_comb begin
    diff    = $signed({1'b0, req_i.other}) - $signed({1'b0, req_i.base});
    prod    = $signed({1'b0, req_i.frac}) * diff;
    shifted = prod >>> cbd_pkg::FRAC_W;
    sum     = $signed({2'b00, req_i.base}) + shifted[9:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= sum[7:0];
    end
  end

endmodule

[sv/center_crop_bilinear_downscaler.sv]
// center-crop bilinear downscaler, top level with sequencer and line buffers
// sequence: a pixel with no result passes the row and column target checks and frees
// the input; each result word adds three read states, three blend states and an output
// state, more while the output stalls; a frame-start pixel adds the step-size multiply
// throughput: one pixel at a time; the sequencer and the shared blend unit set the rate
// reset: counters, step size and sequencer clear; line buffers are undefined until written
module center_crop_bilinear_downscaler #(
  parameter int OUT_SIZE   = 48,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cbd_pkg::PIX_W-1:0]     pixel_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [cbd_pkg::PIX_W-1:0] value_o,
  output logic [cbd_pkg::COORD_W-1:0]   out_col_o,
  output logic [cbd_pkg::COORD_W-1:0]   out_row_o,
  output logic                          run_last_o,
  output logic                          image_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [cbd_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int MAXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W0 = $clog2(MAXD + 1);
  localparam int DIM_W  = (DIM_W0 > cbd_pkg::CFG_W) ? DIM_W0 : cbd_pkg::CFG_W;
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int NUM_W  = DIM_W + cbd_pkg::FIX_SHIFT;
  localparam int POS_W  = DIM_W + cbd_pkg::FIX_SHIFT + 1;
  localparam int EW     = DIM_W + 2;
  localparam int TW     = $clog2(OUT_SIZE + 2);
  localparam int W_RST  = (cbd_pkg::WIDTH_RST < OUT_SIZE) ? OUT_SIZE :
                          ((cbd_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : cbd_pkg::WIDTH_RST);
  localparam int H_RST  = (cbd_pkg::HEIGHT_RST < OUT_SIZE) ? OUT_SIZE :
                          ((cbd_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT :
                           cbd_pkg::HEIGHT_RST);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_DIV  = 14'b00000000000010,
    S_ROW0 = 14'b00000000000100,
    S_ROW1 = 14'b00000000001000,
    S_COL0 = 14'b00000000010000,
    S_COL1 = 14'b00000000100000,
    S_RD0  = 14'b00000001000000,
    S_RD1  = 14'b00000010000000,
    S_RD2  = 14'b00000100000000,
    S_MT   = 14'b00001000000000,
    S_MB   = 14'b00010000000000,
    S_MV   = 14'b00100000000000,
    S_OUT  = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_e;

  state_e st_q, st_d;

  // control registers
  logic [cbd_pkg::CFG_W-1:0] fw_q, fh_q;
  logic [DIM_W-1:0] act_w_q, act_h_q;
  logic [AW-1:0]    col_q;
  logic [DIM_W-1:0] row_q;
  logic [POS_W-1:0] step_q, row_pos_q, col_pos_q;
  logic [TW-1:0]    row_tgt_q, col_tgt_q;
  logic [1:0]       ny_q, nx_q;
  logic             i_q, j_q;
  logic             bank_q;

  // payload registers
  logic [cbd_pkg::PIX_W-1:0] pix_q, p00_q, p10_q, p01_q, top_q;
  logic             ylow_q [2];
  logic [7:0]       fy_q [2];
  logic [TW-1:0]    oy_q [2];
  logic [AW-1:0]    x0_q [2];
  logic [7:0]       fx_q [2];
  logic [TW-1:0]    ox_q [2];

  logic accept;
  assign in_ready_o  = (st_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // new frame size from the registers, clamped
  logic [DIM_W-1:0] new_w, new_h, new_crop, crop, xoff, yoff;
  always_comb begin
    new_w = DIM_W'(fw_q);
    if (new_w < DIM_W'(OUT_SIZE)) new_w = DIM_W'(OUT_SIZE);
    else if (new_w > DIM_W'(MAX_WIDTH)) new_w = DIM_W'(MAX_WIDTH);
    new_h = DIM_W'(fh_q);
    if (new_h < DIM_W'(OUT_SIZE)) new_h = DIM_W'(OUT_SIZE);
    else if (new_h > DIM_W'(MAX_HEIGHT)) new_h = DIM_W'(MAX_HEIGHT);
    new_crop = (new_w < new_h) ? new_w : new_h;
    crop     = (act_w_q < act_h_q) ? act_w_q : act_h_q;
    xoff     = (act_w_q - crop) >> 1;
    yoff     = (act_h_q - crop) >> 1;
  end

  // step size unit
  logic             div_done;
  logic [NUM_W-1:0] div_quot;
  cbd_div #(
    .DimW    (DIM_W),
    .Shift   (cbd_pkg::FIX_SHIFT),
    .Divisor (OUT_SIZE)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && frame_start_i),
    .dividend_i (new_crop),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // shared target evaluator for row and column candidates
  logic             sel_col, k1, ev_hit, ev_ylow;
  logic [POS_W-1:0] ev_p;
  logic [DIM_W-1:0] ev_off, ev_act, ev_cur;
  logic [TW-1:0]    ev_tgt;
  logic [EW-1:0]    e0, e1, e_next;
  always_comb begin
    sel_col = (st_q == S_COL0) || (st_q == S_COL1);
    k1      = (st_q == S_ROW1) || (st_q == S_COL1);
    ev_p    = (sel_col ? col_pos_q : row_pos_q) + (k1 ? step_q : '0);
    ev_off  = sel_col ? xoff : yoff;
    ev_act  = sel_col ? act_w_q : act_h_q;
    ev_cur  = sel_col ? DIM_W'(col_q) : row_q;
    ev_tgt  = sel_col ? col_tgt_q : row_tgt_q;
    e0      = EW'(ev_p[POS_W-1:cbd_pkg::FIX_SHIFT]) + EW'(ev_off);
    e1      = e0 + 1'b1;
    e_next  = (e1 >= EW'(ev_act)) ? EW'(ev_act) - 1'b1 : e1;
    ev_hit  = ((ev_tgt + TW'(k1)) < TW'(OUT_SIZE)) && (e_next == EW'(ev_cur));
    ev_ylow = (e0 == EW'(row_q));
  end

  // line buffers, ping-pong; bank_q names the one holding the current row
  logic [AW-1:0] wr_col, lower_raddr, upper_raddr, raddr0, raddr1;
  logic [cbd_pkg::PIX_W-1:0] rdata0, rdata1, lower_rd, upper_rd;
  always_comb begin
    wr_col      = frame_start_i ? '0 : col_q;
    lower_raddr = x0_q[j_q];
    upper_raddr = (st_q == S_RD0) ? x0_q[j_q] : col_q;
    raddr0      = bank_q ? upper_raddr : lower_raddr;
    raddr1      = bank_q ? lower_raddr : upper_raddr;
    lower_rd    = bank_q ? rdata1 : rdata0;
    upper_rd    = bank_q ? rdata0 : rdata1;
  end

  cbd_ram #(.Width(cbd_pkg::PIX_W), .Depth(MAX_WIDTH)) u_line0 (
    .clk_i   (clk_i),
    .we_i    (accept && !bank_q),
    .waddr_i (wr_col),
    .wdata_i (pixel_i),
    .raddr_i (raddr0),
    .rdata_o (rdata0)
  );

  cbd_ram #(.Width(cbd_pkg::PIX_W), .Depth(MAX_WIDTH)) u_line1 (
    .clk_i   (clk_i),
    .we_i    (accept && bank_q),
    .waddr_i (wr_col),
    .wdata_i (pixel_i),
    .raddr_i (raddr1),
    .rdata_o (rdata1)
  );

  // shared blend unit
  cbd_pkg::blend_req_t blend_req;
  logic                blend_en;
  logic [cbd_pkg::PIX_W-1:0] blend_res;
  always_comb begin
    blend_en = (st_q == S_MT) || (st_q == S_MB) || (st_q == S_MV);
    if (st_q == S_MT) begin
      blend_req = '{frac: fx_q[j_q], base: p00_q, other: p10_q};
    end else if (st_q == S_MB) begin
      blend_req = '{frac: fx_q[j_q], base: p01_q, other: pix_q};
    end else begin
      blend_req = '{frac: fy_q[i_q], base: top_q, other: blend_res};
    end
  end

  cbd_blend u_blend (
    .clk_i (clk_i),
    .en_i  (blend_en),
    .req_i (blend_req),
    .res_o (blend_res)
  );

  logic out_free, last_res, row_end;
  assign out_free = !out_valid_o || out_ready_i;
  assign last_res = (j_q == nx_q[1]) && (i_q == ny_q[1]);
  assign row_end  = ((DIM_W+1)'(col_q) + 1'b1) >= (DIM_W+1)'(act_w_q);

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (accept) st_d = frame_start_i ? S_DIV : S_ROW0;
      S_DIV:  if (div_done) st_d = S_ROW0;
      S_ROW0: begin
        if (step_q == '0) st_d = S_FIN;
        else st_d = ev_hit ? S_ROW1 : S_COL0;
      end
      S_ROW1: st_d = S_COL0;
      S_COL0: begin
        if (ev_hit) st_d = S_COL1;
        else st_d = S_FIN;
      end
      S_COL1: st_d = (ny_q != 2'd0) ? S_RD0 : S_FIN;
      S_RD0:  st_d = S_RD1;
      S_RD1:  st_d = S_RD2;
      S_RD2:  st_d = S_MT;
      S_MT:   st_d = S_MB;
      S_MB:   st_d = S_MV;
      S_MV:   st_d = S_OUT;
      S_OUT: begin
        if (out_free) st_d = last_res ? S_FIN : S_RD0;
      end
      S_FIN:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
    // a single column hit still produces results when rows matched
    if (st_q == S_COL0 && ev_hit == 1'b0 && nx_q == 2'd0) st_d = S_FIN;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      fw_q      <= cbd_pkg::CFG_W'(cbd_pkg::WIDTH_RST);
      fh_q      <= cbd_pkg::CFG_W'(cbd_pkg::HEIGHT_RST);
      act_w_q   <= DIM_W'(W_RST);
      act_h_q   <= DIM_W'(H_RST);
      col_q     <= '0;
      row_q     <= '0;
      step_q    <= '0;
      row_pos_q <= '0;
      col_pos_q <= '0;
      row_tgt_q <= '0;
      col_tgt_q <= '0;
      ny_q      <= '0;
      nx_q      <= '0;
      i_q       <= 1'b0;
      j_q       <= 1'b0;
      bank_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      // configuration writes
      if (cfg_valid_i) begin
        unique case (cbd_pkg::cfg_idx_e'(cfg_index_i))
          cbd_pkg::CFG_WIDTH:  fw_q <= cfg_data_i;
          cbd_pkg::CFG_HEIGHT: fh_q <= cfg_data_i;
          default: ;
        endcase
      end
      // output word valid
      if (st_q == S_OUT && out_free) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          ny_q <= '0;
          nx_q <= '0;
          if (accept && frame_start_i) begin
            act_w_q   <= new_w;
            act_h_q   <= new_h;
            col_q     <= '0;
            row_q     <= '0;
            row_pos_q <= '0;
            col_pos_q <= '0;
            row_tgt_q <= '0;
            col_tgt_q <= '0;
          end
        end
        S_DIV: if (div_done) step_q <= POS_W'(div_quot);
        S_ROW0: if (step_q != '0 && ev_hit) ny_q <= 2'd1;
        S_ROW1: if (ev_hit) ny_q <= 2'd2;
        S_COL0: begin
          if (ev_hit) nx_q <= 2'd1;
          i_q <= 1'b0;
          j_q <= 1'b0;
        end
        S_COL1: if (ev_hit) nx_q <= 2'd2;
        S_OUT: begin
          if (out_free) begin
            if (j_q != nx_q[1]) begin
              j_q <= 1'b1;
            end else begin
              j_q <= 1'b0;
              i_q <= 1'b1;
            end
          end
        end
        S_FIN: begin
          if (row_end) begin
            bank_q    <= ~bank_q;
            col_q     <= '0;
            if (row_q < DIM_W'(MAX_HEIGHT)) row_q <= row_q + 1'b1;
            col_tgt_q <= '0;
            col_pos_q <= '0;
            row_tgt_q <= row_tgt_q + TW'(ny_q);
            row_pos_q <= row_pos_q + (ny_q[1] ? (step_q << 1) :
                                      (ny_q[0] ? step_q : '0));
          end else begin
            col_q     <= col_q + 1'b1;
            col_tgt_q <= col_tgt_q + TW'(nx_q);
            col_pos_q <= col_pos_q + (nx_q[1] ? (step_q << 1) :
                                      (nx_q[0] ? step_q : '0));
          end
        end
        default: ;
      endcase
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (accept) pix_q <= pixel_i;
    if (st_q == S_ROW0 || st_q == S_ROW1) begin
      ylow_q[k1] <= ev_ylow;
      fy_q[k1]   <= ev_p[cbd_pkg::FIX_SHIFT-1:cbd_pkg::FIX_SHIFT-cbd_pkg::FRAC_W];
      oy_q[k1]   <= ev_tgt + TW'(k1);
    end
    if (st_q == S_COL0 || st_q == S_COL1) begin
      x0_q[k1] <= e0[AW-1:0];
      fx_q[k1] <= ev_p[cbd_pkg::FIX_SHIFT-1:cbd_pkg::FIX_SHIFT-cbd_pkg::FRAC_W];
      ox_q[k1] <= ev_tgt + TW'(k1);
    end
    if (st_q == S_RD1) begin
      p01_q <= lower_rd;
      p00_q <= ylow_q[i_q] ? lower_rd : upper_rd;
    end
    if (st_q == S_RD2) p10_q <= ylow_q[i_q] ? pix_q : upper_rd;
    if (st_q == S_MB) top_q <= blend_res;
    // result word
    if (st_q == S_OUT && out_free) begin
      value_o      <= blend_res ^ cbd_pkg::PIX_OFFSET;
      out_col_o    <= cbd_pkg::COORD_W'(ox_q[j_q]);
      out_row_o    <= cbd_pkg::COORD_W'(oy_q[i_q]);
      run_last_o   <= last_res;
      image_done_o <= (oy_q[i_q] == TW'(OUT_SIZE - 1)) && (ox_q[j_q] == TW'(OUT_SIZE - 1));
    end
  end

endmodule
